### hdl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Types and constants shared by the SHA-1 engine modules.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef logic [31:0] word5_t [5];

  localparam int unsigned SHA1_ROUNDS = 80;
  localparam int unsigned BlockBytes  = 64;
  localparam int unsigned LenStartPos = 56;
  localparam int unsigned DigestWords = 5;

  localparam word5_t SHA1_H_INIT = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam logic [31:0] SHA1_K [4] = '{
    32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
  };

  localparam logic [7:0] SHA1_PAD_BYTE = 8'h80;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_EMIT
  } sha1_state_e;

  // schedule line control
  typedef struct packed {
    logic push;   // one message byte enters the word packer
    logic shift;  // one round consumes a schedule word
  } sched_ctrl_t;

  // round unit control
  typedef struct packed {
    logic load;   // copy chaining words into the working words
    logic step;   // run one round
  } round_ctrl_t;

endpackage

### hdl/sha1_if.sv
// ----------------------------------------------------------------------------
// sha1_if
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### hdl/sha1_sched.sv
// ----------------------------------------------------------------------------
// sha1_sched
// Packs bytes big-endian into words and holds the 16-word message schedule
// as a shift line; during rounds it extends the schedule one word a cycle.
// ----------------------------------------------------------------------------
module sha1_sched (
  input  logic                 clk_i,
  input  sha1_pkg::sched_ctrl_t ctrl_i,
  input  logic [7:0]           byte_i,
  input  logic [1:0]           slot_i,
  output logic [31:0]          w_o
);
  import sha1_pkg::*;

  logic [23:0] acc_q;
  logic [31:0] line_q [16];
  logic [31:0] expand;
  logic [31:0] new_word;
  logic        line_shift;

  // next schedule word from the fixed taps
  always_comb begin
    expand = line_q[13] ^ line_q[8] ^ line_q[2] ^ line_q[0];
    expand = {expand[30:0], expand[31]};
  end

  assign line_shift = ctrl_i.shift || (ctrl_i.push && (slot_i == 2'd3));
  assign new_word   = ctrl_i.shift ? expand : {acc_q, byte_i};

  // byte packer
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      case (slot_i)
        2'd0:    acc_q[23:16] <= byte_i;
        2'd1:    acc_q[15:8]  <= byte_i;
        2'd2:    acc_q[7:0]   <= byte_i;
        default: acc_q        <= acc_q;
      endcase
    end
  end

  // schedule shift line, oldest word at tap zero
  always_ff @(posedge clk_i) begin
    if (line_shift) begin
      for (int i = 0; i < 15; i++) begin
        line_q[i] <= line_q[i+1];
      end
      line_q[15] <= new_word;
    end
  end

  assign w_o = line_q[0];

endmodule

### hdl/sha1_round.sv
// ----------------------------------------------------------------------------
// sha1_round
// Working words a..e, the round counter and the single round datapath that
// is reused for all 80 rounds of a block.
// ----------------------------------------------------------------------------
module sha1_round (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha1_pkg::round_ctrl_t ctrl_i,
  input  sha1_pkg::word5_t      chain_i,
  input  logic [31:0]           w_i,
  output sha1_pkg::word5_t      work_o,
  output logic                  last_o
);
  import sha1_pkg::*;

  logic [6:0]  round_q, round_d;
  word5_t      work_q;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;
  logic [31:0] a, b, c, d, e;

  assign a = work_q[0];
  assign b = work_q[1];
  assign c = work_q[2];
  assign d = work_q[3];
  assign e = work_q[4];

  // round function and constant by round group
  always_comb begin
    if (round_q < 7'd20) begin
      f_val = (b & c) | (~b & d);
      k_val = SHA1_K[0];
    end else if (round_q < 7'd40) begin
      f_val = b ^ c ^ d;
      k_val = SHA1_K[1];
    end else if (round_q < 7'd60) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = SHA1_K[2];
    end else begin
      f_val = b ^ c ^ d;
      k_val = SHA1_K[3];
    end
    t_val = {a[26:0], a[31:27]} + f_val + e + k_val + w_i;
  end

  assign last_o = (round_q == 7'(SHA1_ROUNDS - 1));

  // round counter
  always_comb begin
    round_d = round_q;
    if (ctrl_i.load) begin
      round_d = '0;
    end else if (ctrl_i.step) begin
      round_d = last_o ? 7'd0 : round_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= '0;
    end else begin
      round_q <= round_d;
    end
  end

  // working words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        work_q[i] <= '0;
      end
    end else if (ctrl_i.load) begin
      work_q <= chain_i;
    end else if (ctrl_i.step) begin
      work_q[4] <= d;
      work_q[3] <= c;
      work_q[2] <= {b[1:0], b[31:2]};
      work_q[1] <= a;
      work_q[0] <= t_val;
    end
  end

  assign work_o = work_q;

endmodule

### hdl/sha1_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit
// Streaming SHA-1 engine: byte stream in, five digest words out.
// ----------------------------------------------------------------------------
// Input channel in_i: one transaction carries an optional message byte
// (byte_valid) and an optional end_of_message mark. Output channel out_o:
// five transactions per message, h0 first, word_index 0..4, last_word on h4.
// A byte that does not fill a block leaves the input ready for the next
// byte. The byte that fills a 64-byte block closes the input while the
// single round unit runs the 80 rounds and the result is added into the
// chaining words. End of message: padding and length go in one byte per
// cycle, then one compression, or two when the 0x80 falls at byte 56 or
// later; then the five digest words follow, one per cycle while out_o is
// ready. in_i.ready is low from the end mark until h4 is taken.
// A stalled receiver simply holds the current digest word on out_o.
// Reset loads the initial chaining values, clears the bit count and byte
// position and leaves the engine idle and ready.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  sha1_in_if.sink     in_i,
  sha1_out_if.source  out_o
);
  import sha1_pkg::*;

  sha1_state_e state_q, state_d;
  word5_t      chain_q;
  word5_t      work;
  logic [63:0] bit_count_q;
  logic [5:0]  pos_q;
  logic [2:0]  idx_q;
  logic        pad_q, sent80_q, len_act_q;
  logic [31:0] w_word;
  logic        round_last;
  logic        in_acc, out_acc;
  logic        push_en;
  logic [7:0]  push_byte;
  logic [7:0]  len_byte;
  logic [2:0]  len_sel;
  logic        len_now;
  logic        block_full;
  sched_ctrl_t sched_ctrl;
  round_ctrl_t round_ctrl;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // length bytes, most significant first, at positions 56..63
  assign len_sel  = 3'd7 - pos_q[2:0];
  assign len_byte = 8'(bit_count_q >> {len_sel, 3'b000});
  assign len_now  = len_act_q || (sent80_q && (pos_q == 6'(LenStartPos)));

  // byte that enters the block this cycle
  always_comb begin
    push_en   = 1'b0;
    push_byte = in_i.data_byte;
    case (state_q)
      ST_IDLE: begin
        push_en = in_acc && in_i.byte_valid;
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (!sent80_q) begin
          push_byte = SHA1_PAD_BYTE;
        end else if (len_now) begin
          push_byte = len_byte;
        end else begin
          push_byte = '0;
        end
      end
      default: push_en = 1'b0;
    endcase
  end

  assign block_full = push_en && (pos_q == 6'(BlockBytes - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (block_full) begin
            state_d = ST_ROUND;
          end else if (in_i.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (block_full) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_last) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (len_act_q) begin
          state_d = ST_EMIT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_acc && (idx_q == 3'(DigestWords - 1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_i.ready       = (state_q == ST_IDLE);
    out_o.valid      = (state_q == ST_EMIT);
    sched_ctrl.push  = push_en;
    sched_ctrl.shift = (state_q == ST_ROUND);
    round_ctrl.load  = (state_d == ST_ROUND) && (state_q != ST_ROUND);
    round_ctrl.step  = (state_q == ST_ROUND);
  end

  // digest word on the output channel
  assign out_o.digest_word = chain_q[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 3'(DigestWords - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // byte position, bit count, padding flags and digest word index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      bit_count_q <= '0;
      pad_q       <= 1'b0;
      sent80_q    <= 1'b0;
      len_act_q   <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (push_en) begin
        pos_q <= pos_q + 6'd1;
      end
      if ((state_q == ST_IDLE) && in_acc) begin
        if (in_i.byte_valid) begin
          bit_count_q <= bit_count_q + 64'd8;
        end
        if (in_i.end_of_message) begin
          pad_q <= 1'b1;
        end
      end
      if (state_q == ST_PAD) begin
        sent80_q <= 1'b1;
        if (len_now) begin
          len_act_q <= 1'b1;
        end
      end
      if (out_acc) begin
        if (idx_q == 3'(DigestWords - 1)) begin
          idx_q       <= '0;
          bit_count_q <= '0;
          pad_q       <= 1'b0;
          sent80_q    <= 1'b0;
          len_act_q   <= 1'b0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  // chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= SHA1_H_INIT;
    end else if (state_q == ST_FINAL) begin
      for (int i = 0; i < 5; i++) begin
        chain_q[i] <= chain_q[i] + work[i];
      end
    end else if (out_acc && (idx_q == 3'(DigestWords - 1))) begin
      chain_q <= SHA1_H_INIT;
    end
  end

  sha1_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .byte_i (push_byte),
    .slot_i (pos_q[1:0]),
    .w_o    (w_word)
  );

  sha1_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (round_ctrl),
    .chain_i (chain_q),
    .w_i     (w_word),
    .work_o  (work),
    .last_o  (round_last)
  );

endmodule

### hdl/sha1_checker.sv
// ----------------------------------------------------------------------------
// sha1_checker
// Port-level checks on the SHA-1 engine: digest words leave as one burst
// of five while the input stays closed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] digest_word_i,
  input logic [2:0]  word_index_i,
  input logic        last_word_i
);

  logic out_acc;
  assign out_acc = out_valid_i && out_ready_i;

  // no input transaction while a digest is being delivered
  `ASSERT_IMPL(a_no_in_during_out, clk_i, rst_ni, out_valid_i, !in_ready_i)

  // a digest word that is not the last is followed by the next index
  `ASSERT_NEXT(a_index_advance, clk_i, rst_ni, out_acc && !last_word_i,
               out_valid_i && (word_index_i == $past(word_index_i) + 3'd1))

  // after the last word the output goes quiet and input reopens
  `ASSERT_NEXT(a_burst_end, clk_i, rst_ni, out_acc && last_word_i,
               !out_valid_i && in_ready_i)

  // stalled digest word holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
               out_valid_i && $stable(digest_word_i) && $stable(word_index_i))

endmodule

bind sha1_hash_engine_unit sha1_checker u_sha1_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .digest_word_i (out_o.digest_word),
  .word_index_i  (out_o.word_index),
  .last_word_i   (out_o.last_word)
);

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming SHA-1 engine. A queue of byte
// transactions (short directed messages, then random messages with ignored
// noise bytes) feeds a valid/ready driver. A local SHA-1 predictor runs on
// every accepted input transaction and queues the five digest words expected
// on an end mark. A monitor compares each accepted output transaction field
// by field. Both sides insert random gaps, with calm stretches in between.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned StimItems   = 430;
  localparam int unsigned IdleLimit   = 2000;  // watchdog limit, above the worst legal pause
  localparam int unsigned DrainCycles = 300;   // padding, two blocks, word drain

  localparam logic [31:0] ChainInit [5] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };
  localparam logic [31:0] RoundK [4] = '{
    32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
  };
  localparam logic [7:0] PadMark = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } byte_txn_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_txn_t;

  logic clk_i;
  logic rst_ni;

  sha1_in_if  in_ch ();
  sha1_out_if out_ch ();

  sha1_hash_engine_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // stimulus and expectation stores
  byte_txn_t   byte_stream [$];
  digest_txn_t digest_words_due [$];

  // predictor state
  logic [31:0] chain_q [5];
  logic [31:0] sched_q [16];
  logic [63:0] msg_bits;
  logic [5:0]  fill_pos;

  // driver / monitor bookkeeping
  byte_txn_t   held_txn;
  logic        in_hold;
  logic        in_taken;
  logic        calm;
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned idle_cycles;
  int unsigned error_count;
  int unsigned queued_items;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // 80 rounds over the current schedule into the chaining words
  task automatic sha_compress();
    logic [31:0] a, b, c, d, e, f, t;
    int unsigned r;
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (r = 0; r < 80; r++) begin
      if (r >= 16)
        sched_q[r % 16] = rotl(sched_q[(r - 3) % 16] ^ sched_q[(r - 8) % 16] ^
                               sched_q[(r - 14) % 16] ^ sched_q[r % 16], 1);
      if (r < 20) f = (b & c) | (~b & d);
      else if (r < 40) f = b ^ c ^ d;
      else if (r < 60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      t = rotl(a, 5) + f + e + RoundK[r / 20] + sched_q[r % 16];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
  endtask

  // big-endian packing into the schedule, compress on a full block
  task automatic absorb_byte(input logic [7:0] b);
    logic [3:0] slot;
    slot = fill_pos[5:2];
    if (fill_pos[1:0] == 2'd0) sched_q[slot] = {b, 24'h0};
    else sched_q[slot] = sched_q[slot] | ({24'h0, b} << (8 * (3 - fill_pos[1:0])));
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) sha_compress();
  endtask

  // one accepted input transaction; an end mark yields five digest words
  task automatic predict_digest(input byte_txn_t txn);
    logic [63:0] len;
    digest_txn_t due_word;
    int i;
    if (txn.byte_valid) begin
      absorb_byte(txn.data_byte);
      msg_bits += 64'd8;
    end
    if (txn.end_of_message) begin
      len = msg_bits;
      absorb_byte(PadMark);
      while (fill_pos != 6'd56) absorb_byte(8'h00);
      for (i = 7; i >= 0; i--) absorb_byte(len[8 * i +: 8]);
      for (i = 0; i < 5; i++) begin
        due_word = '{word: chain_q[i], index: 3'(i), last: (i == 4)};
        digest_words_due = {digest_words_due, due_word};
      end
      chain_q  = ChainInit;
      msg_bits = '0;
      fill_pos = '0;
    end
  endtask

  task automatic add_item(input logic [7:0] data, input logic valid, input logic eom);
    byte_txn_t item;
    item = '{data_byte: data, byte_valid: valid, end_of_message: eom};
    byte_stream = {byte_stream, item};
    queued_items++;
  endtask

  // random message: random bytes, occasional ignored noise, end mark on the
  // last byte or on a separate item without a byte
  task automatic add_message(input int unsigned n_bytes);
    int unsigned k;
    logic split_end;
    split_end = (n_bytes == 0) || ($urandom_range(0, 1) == 1);
    for (k = 0; k < n_bytes; k++) begin
      if ($urandom_range(0, 7) == 0) add_item(8'($urandom), 1'b0, 1'b0);
      add_item(8'($urandom), 1'b1, !split_end && (k == n_bytes - 1));
    end
    if (split_end) add_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // input driver, changes at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_hold  = 1'b0;
      end
      if (!in_hold) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (byte_stream.size() > 0) begin
          held_txn = byte_stream.pop_front();
          in_hold  = 1'b1;
          in_gap   = pick_gap();
        end
      end
      in_ch.valid <= in_hold;
      if (in_hold) begin
        in_ch.data_byte      <= held_txn.data_byte;
        in_ch.byte_valid     <= held_txn.byte_valid;
        in_ch.end_of_message <= held_txn.end_of_message;
      end else begin
        in_ch.data_byte      <= 8'($urandom);
        in_ch.byte_valid     <= 1'($urandom);
        in_ch.end_of_message <= 1'($urandom);
      end
    end
  end

  // output back-pressure, with calm stretches toggled at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 299) == 0) calm = !calm;
      if (out_stall > 0) out_stall--;
      else out_stall = pick_gap();
      out_ch.ready <= (out_stall == 0);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    digest_txn_t due;
    logic        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        moved    = 1'b1;
        in_taken = 1'b1;
        predict_digest('{data_byte: in_ch.data_byte, byte_valid: in_ch.byte_valid,
                         end_of_message: in_ch.end_of_message});
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (digest_words_due.size() == 0) begin
          report_mismatch($sformatf("unexpected digest word %h index %0d",
                                    out_ch.digest_word, out_ch.word_index));
        end else begin
          due = digest_words_due.pop_front();
          if (out_ch.digest_word !== due.word)
            report_mismatch($sformatf("digest word %0d: got %h, expected %h",
                                      due.index, out_ch.digest_word, due.word));
          if (out_ch.word_index !== due.index)
            report_mismatch($sformatf("word index: got %0d, expected %0d",
                                      out_ch.word_index, due.index));
          if (out_ch.last_word !== due.last)
            report_mismatch($sformatf("last mark on word %0d: got %b, expected %b",
                                      due.index, out_ch.last_word, due.last));
        end
      end
      // watchdog on cycles without any transaction
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // reset, stimulus, end of run
  initial begin
    int unsigned boundary [4];
    int unsigned k;
    int unsigned roll;
    boundary = '{55, 56, 63, 64};
    rst_ni = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = 8'h00;
    in_ch.byte_valid     = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready         = 1'b0;
    chain_q     = ChainInit;
    sched_q     = '{default: '0};
    msg_bits    = '0;
    fill_pos    = '0;
    in_hold     = 1'b0;
    in_taken    = 1'b0;
    calm        = 1'b0;
    in_gap      = 0;
    out_stall   = 0;
    idle_cycles = 0;
    error_count = 0;
    queued_items = 0;

    // empty message
    add_item(8'h00, 1'b0, 1'b1);
    // ignored byte, then empty message again
    add_item(8'hFF, 1'b0, 1'b0);
    add_item(8'hFF, 1'b0, 1'b1);
    // "abc", end mark on the last byte
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);
    add_item(8'h63, 1'b1, 1'b1);
    // extreme byte values, end mark on a separate item
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0);
    add_item(8'h55, 1'b0, 1'b0);
    add_item(8'hAA, 1'b1, 1'b0);
    add_item(8'h5A, 1'b0, 1'b1);
    // single byte messages
    add_item(8'hFF, 1'b1, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);

    // padding edges: 0x80 just before, at and past the length field, full block
    for (k = 0; k < 4; k++) add_message(boundary[k]);
    // random messages, mostly short
    while (queued_items < StimItems) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) add_message($urandom_range(0, 8));
      else if (roll < 85) add_message($urandom_range(9, 40));
      else add_message($urandom_range(41, 70));
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_stream.size() > 0 || in_hold || digest_words_due.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
